### hw/rtl/qwls_pkg.sv
package qwls_pkg;

    // Lattice size and cell address width
    localparam int CELLS  = 256;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

    // Field widths
    localparam int IDX_W  = 8;
    localparam int AMP_W  = 16;
    localparam int CPLX_W = 2 * AMP_W;
    localparam int DENS_W = 34;

    // Stream payload widths, padded to whole bytes
    localparam int IN_BITS   = 2 + IDX_W + 4 * AMP_W;
    localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = IDX_W + 4 * AMP_W + DENS_W;
    localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

    // Coin register reset values
    localparam logic [14:0]        COIN_COS_RST = 15'd23170;
    localparam logic signed [15:0] COIN_SIN_RST = 16'sd23170;

    // Rounding offset for Q2.30 to Q1.15
    localparam logic signed [32:0] HALF_LSB = 33'sd16384;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    typedef enum logic [0:0] {
        CFG_COIN_COS = 1'b0,
        CFG_COIN_SIN = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_DRAIN,
        ST_WRAP,
        ST_RD1,
        ST_RD2,
        ST_RD3
    } t_state;

    // One port's write request
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CPLX_W-1:0] data;
    } t_wr_req;

    // Round to nearest (ties up) and saturate a Q2.30 sum to Q1.15
    function automatic logic signed [AMP_W-1:0] round_sat(input logic signed [32:0] v);
        logic signed [32:0] t;
        logic signed [17:0] q;
        t = v + HALF_LSB;
        q = 18'(t >>> 15);
        if (q > 18'sd32767) begin
            return 16'sh7fff;
        end else if (q < -18'sd32768) begin
            return 16'sh8000;
        end
        return q[AMP_W-1:0];
    endfunction

endpackage

### hw/rtl/qwls_ram.sv
module qwls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry with a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/quantum_walk_lattice_step.sv
// Write item: the next item is taken in the following cycle.
// Read item: the item steps through RD1, RD2 and RD3 to the registered result, then held
//   until taken; the next item is taken once RD3 finds the result register free.
// Step item: one memory read per cell, a 3-stage
//   coin pipeline, and one extra write for the wrapped left amplitude.
// Reset (i_rst_n low, synchronous) restores the coin registers and starts a
//   clearing pass over both amplitude memories; no item is taken.
module quantum_walk_lattice_step (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // cfg: index 0 coin_cos (15 bits), index 1 coin_sin (16 bits)
    input  logic                              i_cfg_wen,
    input  logic [0:0]                        i_cfg_idx,
    input  logic [15:0]                       i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // opcode[1:0], cell_index[9:2], right_real[25:10], right_imag[41:26],
    // left_real[57:42], left_imag[73:58], zero pad
    input  logic [qwls_pkg::IN_TDATA-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // read_index[7:0], out_right_real[23:8], out_right_imag[39:24],
    // out_left_real[55:40], out_left_imag[71:56], density[105:72], zero pad
    output logic [qwls_pkg::OUT_TDATA-1:0]    m_axis_tdata
);

    localparam int AW = qwls_pkg::ADDR_W;
    localparam int CW = qwls_pkg::CPLX_W;

    // Input item fields
    logic [1:0]               in_op;
    logic [qwls_pkg::IDX_W-1:0] in_idx;
    logic [CW-1:0]            in_right;
    logic [CW-1:0]            in_left;
    logic                     in_range;
    logic [AW-1:0]            in_addr;

    assign in_op    = s_axis_tdata[1:0];
    assign in_idx   = s_axis_tdata[9:2];
    assign in_right = s_axis_tdata[41:10];
    assign in_left  = s_axis_tdata[73:42];
    assign in_range = 32'(in_idx) < qwls_pkg::CELLS;
    assign in_addr  = AW'(in_idx);

    // Control state
    qwls_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_cnt, n_cnt;

    // Coin registers
    logic [14:0]        r_coin_cos;
    logic signed [15:0] r_coin_sin;

    // Memory ports
    qwls_pkg::t_wr_req wr_r, wr_l;
    logic [AW-1:0]     raddr;
    logic [CW-1:0]     rdata_r, rdata_l;

    // Step pipeline
    logic                r_v1, r_v2, r_v3;
    logic [AW-1:0]       r_x1, r_x2, r_x3;
    logic signed [31:0]  r_p [8];
    logic signed [15:0]  r_nr_re, r_nr_im, r_nl_re, r_nl_im;
    logic [CW-1:0]       r_wrap_l;

    // Read path
    logic [qwls_pkg::IDX_W-1:0] r_rd_idx;
    logic                       r_rd_oob;
    logic signed [15:0]         r_a_rr, r_a_ri, r_a_lr, r_a_li;
    logic [qwls_pkg::DENS_W-1:0] r_sq_re, r_sq_im;
    logic                       out_free;

    // Output register
    logic                        r_m_valid;
    logic [qwls_pkg::OUT_BITS-1:0] r_m_data;

    assign out_free = !r_m_valid || m_axis_tready;

    qwls_ram #(.WIDTH(CW), .DEPTH(qwls_pkg::CELLS)) u_right_mem (
        .i_clk   (i_clk),
        .i_we    (wr_r.we),
        .i_waddr (wr_r.addr),
        .i_wdata (wr_r.data),
        .i_raddr (raddr),
        .o_rdata (rdata_r)
    );

    qwls_ram #(.WIDTH(CW), .DEPTH(qwls_pkg::CELLS)) u_left_mem (
        .i_clk   (i_clk),
        .i_we    (wr_l.we),
        .i_waddr (wr_l.addr),
        .i_wdata (wr_l.data),
        .i_raddr (raddr),
        .o_rdata (rdata_l)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qwls_pkg::ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state, memory port control, handshake
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        s_axis_tready = 1'b0;
        raddr         = r_cnt;
        wr_r          = '{we: 1'b0, addr: r_cnt, data: '0};
        wr_l          = '{we: 1'b0, addr: r_cnt, data: '0};

        // Stage-3 coin results go back to the shifted cells
        if (r_v3) begin
            wr_r.we   = 1'b1;
            wr_r.addr = (r_x3 == qwls_pkg::LAST_CELL) ? '0 : r_x3 + 1'b1;
            wr_r.data = {r_nr_im, r_nr_re};
            wr_l.we   = (r_x3 != '0);
            wr_l.addr = r_x3 - 1'b1;
            wr_l.data = {r_nl_im, r_nl_re};
        end

        unique case (r_state)
            qwls_pkg::ST_CLEAR: begin
                wr_r.we = 1'b1;
                wr_l.we = 1'b1;
                if (r_cnt == qwls_pkg::LAST_CELL) begin
                    n_cnt   = '0;
                    n_state = qwls_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            qwls_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                raddr         = in_addr;
                if (s_axis_tvalid) begin
                    unique case (in_op)
                        qwls_pkg::OP_WRITE: begin
                            wr_r = '{we: in_range, addr: in_addr, data: in_right};
                            wr_l = '{we: in_range, addr: in_addr, data: in_left};
                        end
                        qwls_pkg::OP_STEP: begin
                            n_cnt   = '0;
                            n_state = qwls_pkg::ST_STEP;
                        end
                        qwls_pkg::OP_READ: begin
                            n_state = qwls_pkg::ST_RD1;
                        end
                        default: begin
                            n_state = qwls_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            qwls_pkg::ST_STEP: begin
                // Issue one cell read per cycle
                if (r_cnt == qwls_pkg::LAST_CELL) begin
                    n_cnt   = '0;
                    n_state = qwls_pkg::ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            qwls_pkg::ST_DRAIN: begin
                if (r_v3 && r_x3 == qwls_pkg::LAST_CELL) begin
                    n_state = qwls_pkg::ST_WRAP;
                end
            end
            qwls_pkg::ST_WRAP: begin
                // Left amplitude of cell 0 lands on the last cell
                wr_l    = '{we: 1'b1, addr: qwls_pkg::LAST_CELL, data: r_wrap_l};
                n_state = qwls_pkg::ST_IDLE;
            end
            qwls_pkg::ST_RD1: n_state = qwls_pkg::ST_RD2;
            qwls_pkg::ST_RD2: n_state = qwls_pkg::ST_RD3;
            qwls_pkg::ST_RD3: begin
                if (out_free) begin
                    n_state = qwls_pkg::ST_IDLE;
                end
            end
            default: n_state = qwls_pkg::ST_IDLE;
        endcase
    end

    // Coin registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coin_cos <= qwls_pkg::COIN_COS_RST;
            r_coin_sin <= qwls_pkg::COIN_SIN_RST;
        end else if (i_cfg_wen) begin
            unique case (qwls_pkg::t_cfg_reg'(i_cfg_idx))
                qwls_pkg::CFG_COIN_COS: r_coin_cos <= i_cfg_wdata[14:0];
                qwls_pkg::CFG_COIN_SIN: r_coin_sin <= i_cfg_wdata;
            endcase
        end
    end

    // Step pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= (r_state == qwls_pkg::ST_STEP);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Coin products from the fresh memory data
    logic signed [15:0] c_s, s_s, m_rr, m_ri, m_lr, m_li;
    assign c_s  = $signed({1'b0, r_coin_cos});
    assign s_s  = r_coin_sin;
    assign m_rr = rdata_r[15:0];
    assign m_ri = rdata_r[31:16];
    assign m_lr = rdata_l[15:0];
    assign m_li = rdata_l[31:16];

    always_ff @(posedge i_clk) begin
        // Stage 1: eight products
        r_x1 <= r_cnt;
        r_x2 <= r_x1;
        r_p[0] <= c_s * m_rr;
        r_p[1] <= s_s * m_li;
        r_p[2] <= c_s * m_ri;
        r_p[3] <= s_s * m_lr;
        r_p[4] <= c_s * m_lr;
        r_p[5] <= s_s * m_ri;
        r_p[6] <= c_s * m_li;
        r_p[7] <= s_s * m_rr;
        // Stage 2: sum, round, saturate
        r_x3    <= r_x2;
        r_nr_re <= qwls_pkg::round_sat(33'(r_p[0]) - 33'(r_p[1]));
        r_nr_im <= qwls_pkg::round_sat(33'(r_p[2]) + 33'(r_p[3]));
        r_nl_re <= qwls_pkg::round_sat(33'(r_p[4]) - 33'(r_p[5]));
        r_nl_im <= qwls_pkg::round_sat(33'(r_p[6]) + 33'(r_p[7]));
        // Hold cell 0's left result until the last cell has been read
        if (r_v3 && r_x3 == '0) begin
            r_wrap_l <= {r_nl_im, r_nl_re};
        end
    end

    // Read path: capture, square the sums
    logic signed [16:0] sum_re, sum_im;
    logic signed [33:0] sq_re_full, sq_im_full;
    assign sum_re     = 17'(r_a_rr) + 17'(r_a_lr);
    assign sum_im     = 17'(r_a_ri) + 17'(r_a_li);
    assign sq_re_full = sum_re * sum_re;
    assign sq_im_full = sum_im * sum_im;

    always_ff @(posedge i_clk) begin
        if (r_state == qwls_pkg::ST_IDLE) begin
            r_rd_idx <= in_idx;
            r_rd_oob <= !in_range;
        end
        if (r_state == qwls_pkg::ST_RD1) begin
            r_a_rr <= r_rd_oob ? '0 : m_rr;
            r_a_ri <= r_rd_oob ? '0 : m_ri;
            r_a_lr <= r_rd_oob ? '0 : m_lr;
            r_a_li <= r_rd_oob ? '0 : m_li;
        end
        if (r_state == qwls_pkg::ST_RD2) begin
            r_sq_re <= sq_re_full;
            r_sq_im <= sq_im_full;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == qwls_pkg::ST_RD3 && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == qwls_pkg::ST_RD3 && out_free) begin
            r_m_data <= {r_sq_re + r_sq_im, r_a_li, r_a_lr, r_a_ri, r_a_rr, r_rd_idx};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {(qwls_pkg::OUT_TDATA - qwls_pkg::OUT_BITS)'(0), r_m_data};

`ifndef SYNTHESIS
    // No item is taken while the clearing pass or a step is running
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qwls_pkg::ST_CLEAR || r_v1 || r_v2 || r_v3) |-> !s_axis_tready)
        else $error("item accepted while memories busy");

    // Right write-back to cell x+1 trails the read of that cell
    a_step_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qwls_pkg::ST_STEP && r_v3) |-> (r_cnt == AW'(r_x3 + 2'd3)))
        else $error("step write-back overtakes reads");

    // A result appears only from the last read stage
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == qwls_pkg::ST_RD3))
        else $error("result without a read");

    // The wrap write follows the last cell's write-back
    a_wrap_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qwls_pkg::ST_WRAP) |-> ($past(r_state) == qwls_pkg::ST_DRAIN && !r_v3))
        else $error("wrap write out of order");
`endif

endmodule

### bench/tb_quantum_walk_lattice_step.sv
module tb_quantum_walk_lattice_step;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]                 OP_UNUSED        = 2'd3;
    localparam logic [qwls_pkg::AMP_W-1:0] AMP_MAX          = 16'h7fff;
    localparam logic [qwls_pkg::AMP_W-1:0] AMP_MIN          = 16'h8000;
    localparam int                         SETTLE_CYCLES    = qwls_pkg::CELLS + 24;
    localparam int                         RUN_LIMIT_CYCLES = 1_000_000;
    localparam int                         RANDOM_ITEMS     = 600;
    localparam int                         PHASES           = 6;

    // One input item, unpacked
    typedef struct {
        logic [1:0]                        op;
        logic [qwls_pkg::IDX_W-1:0]        idx;
        logic signed [qwls_pkg::AMP_W-1:0] rr;
        logic signed [qwls_pkg::AMP_W-1:0] ri;
        logic signed [qwls_pkg::AMP_W-1:0] lr;
        logic signed [qwls_pkg::AMP_W-1:0] li;
    } t_walk_item;

    // One read result, unpacked
    typedef struct {
        logic [qwls_pkg::IDX_W-1:0]  idx;
        logic [qwls_pkg::AMP_W-1:0]  rr;
        logic [qwls_pkg::AMP_W-1:0]  ri;
        logic [qwls_pkg::AMP_W-1:0]  lr;
        logic [qwls_pkg::AMP_W-1:0]  li;
        logic [qwls_pkg::DENS_W-1:0] dens;
    } t_cell_report;

    // Directed row: a typed read carries its expected amplitudes in the data fields
    typedef struct {
        t_walk_item                  item;
        bit                          typed;
        logic [qwls_pkg::DENS_W-1:0] dens;
    } t_dir_row;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_wen     = 1'b0;
    logic [0:0]                     i_cfg_idx     = '0;
    logic [15:0]                    i_cfg_wdata   = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [qwls_pkg::IN_TDATA-1:0]  s_axis_tdata  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [qwls_pkg::OUT_TDATA-1:0] m_axis_tdata;

    quantum_walk_lattice_step uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Lattice shadow: coin registers and both amplitude stores
    logic [14:0]                       coin_cos_q;
    logic signed [qwls_pkg::AMP_W-1:0] coin_sin_q;
    logic signed [qwls_pkg::AMP_W-1:0] rt_re [qwls_pkg::CELLS];
    logic signed [qwls_pkg::AMP_W-1:0] rt_im [qwls_pkg::CELLS];
    logic signed [qwls_pkg::AMP_W-1:0] lf_re [qwls_pkg::CELLS];
    logic signed [qwls_pkg::AMP_W-1:0] lf_im [qwls_pkg::CELLS];

    t_cell_report pending_reads [$];
    t_dir_row     dir_rows [$];
    int           error_count = 0;
    bit           rush        = 1'b0;

    // Clock
    initial begin
        forever #6ns i_clk = ~i_clk;
    end

    // Hard stop on a hang
    initial begin
        repeat (RUN_LIMIT_CYCLES) @(posedge i_clk);
        $display("tb_quantum_walk_lattice_step: done, errors");
        $finish;
    end

    // Round Q2.30 to nearest Q1.15, ties up, then clamp
    function automatic logic signed [qwls_pkg::AMP_W-1:0] round_q15(longint acc);
        longint q;
        q = (acc + 16384) >>> 15;
        if (q > 32767) begin
            q = 32767;
        end else if (q < -32768) begin
            q = -32768;
        end
        return q[qwls_pkg::AMP_W-1:0];
    endfunction

    // Apply the coin to every cell, then move right up and left down with wrap
    function automatic void coin_and_shift();
        logic signed [qwls_pkg::AMP_W-1:0] nr_re [qwls_pkg::CELLS];
        logic signed [qwls_pkg::AMP_W-1:0] nr_im [qwls_pkg::CELLS];
        logic signed [qwls_pkg::AMP_W-1:0] nl_re [qwls_pkg::CELLS];
        logic signed [qwls_pkg::AMP_W-1:0] nl_im [qwls_pkg::CELLS];
        longint c, s, rr, ri, lr, li;
        int up, dn;
        c = longint'(coin_cos_q);
        s = longint'(coin_sin_q);
        for (int x = 0; x < qwls_pkg::CELLS; x++) begin
            rr = rt_re[x];
            ri = rt_im[x];
            lr = lf_re[x];
            li = lf_im[x];
            up = (x + 1) % qwls_pkg::CELLS;
            dn = (x + qwls_pkg::CELLS - 1) % qwls_pkg::CELLS;
            nr_re[up] = round_q15(c * rr - s * li);
            nr_im[up] = round_q15(c * ri + s * lr);
            nl_re[dn] = round_q15(c * lr - s * ri);
            nl_im[dn] = round_q15(c * li + s * rr);
        end
        rt_re = nr_re;
        rt_im = nr_im;
        lf_re = nl_re;
        lf_im = nl_im;
    endfunction

    // Update the shadow for one accepted item; queue the result of a read
    function automatic void apply_item(t_walk_item it);
        t_cell_report rep;
        longint sr, si;
        case (it.op)
            qwls_pkg::OP_WRITE: begin
                if (it.idx < qwls_pkg::CELLS) begin
                    rt_re[it.idx] = it.rr;
                    rt_im[it.idx] = it.ri;
                    lf_re[it.idx] = it.lr;
                    lf_im[it.idx] = it.li;
                end
            end
            qwls_pkg::OP_STEP: begin
                coin_and_shift();
            end
            qwls_pkg::OP_READ: begin
                rep = '{it.idx, '0, '0, '0, '0, '0};
                sr = 0;
                si = 0;
                if (it.idx < qwls_pkg::CELLS) begin
                    rep.rr = rt_re[it.idx];
                    rep.ri = rt_im[it.idx];
                    rep.lr = lf_re[it.idx];
                    rep.li = lf_im[it.idx];
                    sr = longint'(rt_re[it.idx]) + longint'(lf_re[it.idx]);
                    si = longint'(rt_im[it.idx]) + longint'(lf_im[it.idx]);
                end
                rep.dens = qwls_pkg::DENS_W'(sr * sr + si * si);
                pending_reads.push_back(rep);
            end
            default: begin
                // unused opcode: drop
            end
        endcase
    endfunction

    function automatic logic signed [qwls_pkg::AMP_W-1:0] pick_amplitude();
        case ($urandom_range(0, 7))
            0: return AMP_MAX;
            1: return AMP_MIN;
            2: return '0;
            3: return qwls_pkg::AMP_W'($urandom_range(0, 511)) - qwls_pkg::AMP_W'(256);
            default: return qwls_pkg::AMP_W'($urandom);
        endcase
    endfunction

    function automatic void add_row(logic [1:0] op, logic [qwls_pkg::IDX_W-1:0] idx,
                                    logic [qwls_pkg::AMP_W-1:0] rr = '0,
                                    logic [qwls_pkg::AMP_W-1:0] ri = '0,
                                    logic [qwls_pkg::AMP_W-1:0] lr = '0,
                                    logic [qwls_pkg::AMP_W-1:0] li = '0,
                                    bit typed = 1'b0,
                                    logic [qwls_pkg::DENS_W-1:0] dens = '0);
        t_dir_row row;
        row.item  = '{op, idx, rr, ri, lr, li};
        row.typed = typed;
        row.dens  = dens;
        dir_rows.push_back(row);
    endfunction

    task automatic report_mismatch(string field, logic [qwls_pkg::IDX_W-1:0] idx,
                                   logic [qwls_pkg::DENS_W-1:0] got,
                                   logic [qwls_pkg::DENS_W-1:0] want);
        $display("%0t ns: mismatch cell %0d %s: got %h want %h", $time, idx, field, got, want);
        error_count++;
    endtask

    // Drive one item after a random gap, or none when rushing, hold until the handshake
    task automatic send_item(t_walk_item it);
        int gap;
        gap = rush ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= qwls_pkg::IN_TDATA'({it.li, it.lr, it.ri, it.rr, it.idx, it.op});
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    // Wait out all reads, then wait out any step still running
    task automatic settle_block();
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_coin(logic [15:0] cos_w, logic [15:0] sin_w);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= qwls_pkg::CFG_COIN_COS;
        i_cfg_wdata <= cos_w;
        @(posedge i_clk);
        i_cfg_idx   <= qwls_pkg::CFG_COIN_SIN;
        i_cfg_wdata <= sin_w;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        coin_cos_q = cos_w[14:0];
        coin_sin_q = sin_w;
    endtask

    task automatic check_report(logic [qwls_pkg::OUT_TDATA-1:0] d);
        t_cell_report want;
        if (pending_reads.size() == 0) begin
            report_mismatch("unexpected result", d[7:0], d[105:72], '0);
            return;
        end
        want = pending_reads.pop_front();
        if (d[7:0] !== want.idx) report_mismatch("read_index", want.idx, d[7:0], want.idx);
        if (d[23:8] !== want.rr) report_mismatch("right_real", want.idx, d[23:8], want.rr);
        if (d[39:24] !== want.ri) report_mismatch("right_imag", want.idx, d[39:24], want.ri);
        if (d[55:40] !== want.lr) report_mismatch("left_real", want.idx, d[55:40], want.lr);
        if (d[71:56] !== want.li) report_mismatch("left_imag", want.idx, d[71:56], want.li);
        if (d[105:72] !== want.dens) report_mismatch("density", want.idx, d[105:72], want.dens);
    endtask

    // Result side: random stall per item, none when rushing, then take and check
    initial begin
        int stall;
        forever begin
            stall = rush ? 0 : $urandom_range(0, 17);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            check_report(m_axis_tdata);
        end
    end

    // Stimulus
    initial begin
        t_walk_item   it;
        t_cell_report rep;
        logic [15:0]  cos_w, sin_w;
        logic [7:0]   hot_base;
        int           pick, count;

        coin_cos_q = qwls_pkg::COIN_COS_RST;
        coin_sin_q = qwls_pkg::COIN_SIN_RST;
        foreach (rt_re[k]) begin
            rt_re[k] = '0;
            rt_im[k] = '0;
            lf_re[k] = '0;
            lf_im[k] = '0;
        end

        // Directed: cleared store, extremes, unused opcode, wrap of both movers
        add_row(qwls_pkg::OP_READ, 8'd0, '0, '0, '0, '0, 1'b1, '0);
        add_row(qwls_pkg::OP_READ, 8'd255, '0, '0, '0, '0, 1'b1, '0);
        add_row(qwls_pkg::OP_READ, 8'd128);
        add_row(qwls_pkg::OP_WRITE, 8'd0, AMP_MAX, AMP_MAX, AMP_MAX, AMP_MAX);
        add_row(qwls_pkg::OP_READ, 8'd0, AMP_MAX, AMP_MAX, AMP_MAX, AMP_MAX, 1'b1,
                34'd8589410312);
        add_row(qwls_pkg::OP_WRITE, 8'd255, AMP_MIN, AMP_MIN, AMP_MIN, AMP_MIN);
        add_row(qwls_pkg::OP_READ, 8'd255, AMP_MIN, AMP_MIN, AMP_MIN, AMP_MIN, 1'b1,
                34'd8589934592);
        add_row(qwls_pkg::OP_WRITE, 8'd17, AMP_MAX, AMP_MIN, AMP_MIN, AMP_MAX);
        add_row(qwls_pkg::OP_READ, 8'd17, AMP_MAX, AMP_MIN, AMP_MIN, AMP_MAX, 1'b1, 34'd2);
        add_row(OP_UNUSED, 8'd17);
        add_row(qwls_pkg::OP_READ, 8'd17, AMP_MAX, AMP_MIN, AMP_MIN, AMP_MAX, 1'b1, 34'd2);
        add_row(qwls_pkg::OP_WRITE, 8'd5, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
        add_row(qwls_pkg::OP_READ, 8'd5, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 1'b1, 34'd2);
        add_row(qwls_pkg::OP_STEP, 8'd0);
        add_row(qwls_pkg::OP_READ, 8'd1);
        add_row(qwls_pkg::OP_READ, 8'd0);
        add_row(qwls_pkg::OP_READ, 8'd254);
        add_row(qwls_pkg::OP_READ, 8'd255);
        add_row(qwls_pkg::OP_READ, 8'd16);
        add_row(qwls_pkg::OP_READ, 8'd18);
        add_row(qwls_pkg::OP_READ, 8'd4);
        add_row(qwls_pkg::OP_STEP, 8'd255, AMP_MIN, AMP_MAX, AMP_MIN, AMP_MAX);
        add_row(qwls_pkg::OP_STEP, 8'd0);
        add_row(qwls_pkg::OP_READ, 8'd2);
        add_row(qwls_pkg::OP_READ, 8'd253);

        // Hold reset, then release it
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            send_item(dir_rows[n].item);
            if (dir_rows[n].typed) begin
                rep.idx  = dir_rows[n].item.idx;
                rep.rr   = dir_rows[n].item.rr;
                rep.ri   = dir_rows[n].item.ri;
                rep.lr   = dir_rows[n].item.lr;
                rep.li   = dir_rows[n].item.li;
                rep.dens = dir_rows[n].dens;
                pending_reads.push_back(rep);
            end else begin
                apply_item(dir_rows[n].item);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Random phases, each under its own coin
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin cos_w = 16'd32767; sin_w = 16'd0;    end
                1: begin cos_w = 16'd0;     sin_w = 16'h7fff; end
                2: begin cos_w = 16'h8000;  sin_w = 16'h8000; end
                3: begin cos_w = 16'hffff;  sin_w = 16'h8000; end
                4: begin cos_w = 16'($urandom); sin_w = 16'($urandom); end
                default: begin
                    cos_w = 16'(qwls_pkg::COIN_COS_RST);
                    sin_w = qwls_pkg::COIN_SIN_RST;
                end
            endcase
            settle_block();
            write_coin(cos_w, sin_w);
            rush     = (ph % 3 == 1);
            hot_base = 8'($urandom_range(240, 255));
            if (ph % 2 == 1) hot_base = 8'($urandom);
            count = 0;
            while (count < RANDOM_ITEMS / PHASES + 1) begin
                pick    = $urandom_range(0, 99);
                it.op   = (pick < 45) ? qwls_pkg::OP_WRITE : (pick < 88) ? qwls_pkg::OP_READ :
                          (pick < 96) ? qwls_pkg::OP_STEP : OP_UNUSED;
                // half the cells near a hot spot so reads see written and moved data
                it.idx  = $urandom_range(0, 1) ? 8'(hot_base + $urandom_range(0, 15))
                                               : 8'($urandom);
                it.rr   = pick_amplitude();
                it.ri   = pick_amplitude();
                it.lr   = pick_amplitude();
                it.li   = pick_amplitude();
                send_item(it);
                apply_item(it);
                if (it.op != OP_UNUSED) count++;
            end
            s_axis_tvalid <= 1'b0;
        end

        settle_block();
        if (error_count == 0) begin
            $display("tb_quantum_walk_lattice_step: done, clean");
        end else begin
            $display("tb_quantum_walk_lattice_step: done, errors");
        end
        $finish;
    end

endmodule

### quantum_walk_lattice_step.f
hw/rtl/qwls_pkg.sv
hw/rtl/qwls_ram.sv
hw/rtl/quantum_walk_lattice_step.sv
bench/tb_quantum_walk_lattice_step.sv
